/* hw/rtl/bspl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_pkg: shared types and constants for the cubic B-spline evaluator
// Table geometry, register indexes, request codes, queue entry layout and
// the back-end sequencer states.
// ----------------------------------------------------------------------------
package bspl_pkg;

	// control point table
	localparam int MAX_POINTS = 256;
	localparam int PIDX_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = 9;

	// configuration register indexes
	localparam logic [1:0] CFG_INTERVAL = 2'd0;
	localparam logic [1:0] CFG_START    = 2'd1;
	localparam logic [1:0] CFG_COUNT    = 2'd2;

	// request codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// front/back queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// divider geometry
	localparam int DVD_W     = 48;
	localparam int DVS_W     = 64;
	localparam int DIV_STEPS = DVD_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	// floor(y/3) == (y * RECIP3) >> 33 for any 32-bit y
	localparam logic signed [33:0] RECIP3 = 34'sh0AAAAAAAB;

	// one queued transaction, already classified by the front end
	typedef struct packed {
		logic              is_query;
		logic              bad;
		logic [31:0]       stamp;
		logic [PIDX_W-1:0] index;
		logic [31:0]       x;
		logic [31:0]       y;
		logic [31:0]       z;
	} item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DGO,
		S_DWAIT,
		S_CHK,
		S_RD,
		S_WT,
		S_MUL,
		S_MACC,
		S_FIN,
		S_FGO,
		S_FWAIT,
		S_EMIT
	} back_state_t;

	// flat index of (axis, kind) or (kind, term) pairs: a*3 + k
	function automatic logic [3:0] idx9(input logic [1:0] a, input logic [1:0] k);
		idx9 = 4'({a, 1'b0}) + 4'(a) + 4'(k);
	endfunction

	// round-half-up magnitude to signed 32 bits with saturation
	function automatic logic signed [31:0] sat32(input logic neg, input logic [47:0] q);
		logic signed [31:0] r;
		if (!neg) begin
			r = (q > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : signed'(q[31:0]);
		end else begin
			r = (q >= 48'h80000000) ? 32'sh80000000 : signed'(32'(-q[31:0]));
		end
		sat32 = r;
	endfunction

endpackage

/* hw/rtl/bspl_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_div: shared restoring divider
// One quotient bit per cycle over a fixed number of steps; done pulses for
// one cycle with the quotient valid.
// ----------------------------------------------------------------------------
module bspl_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [bspl_pkg::DVD_W-1:0] dvd,
	input  logic [bspl_pkg::DVS_W-1:0] dvs,
	output logic                       done,
	output logic [bspl_pkg::DVD_W-1:0] quo
);
	import bspl_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W:0]    r_sh;
	logic              ge;

	// one restoring step
	always_comb begin
		r_sh = {rem_q, quo_q[DVD_W-1]};
		ge   = r_sh >= {1'b0, dvs_q};
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == DCNT_W'(DIV_STEPS - 1));
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvs_q <= dvs;
			quo_q <= dvd;
		end else if (run_q) begin
			rem_q <= ge ? DVS_W'(r_sh - {1'b0, dvs_q}) : r_sh[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* hw/rtl/bspl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_front: request intake and classification
// Takes transactions, marks queries that fall before the start time or use a
// zero interval, and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module bspl_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [bspl_pkg::PIDX_W-1:0] point_index,
	input  logic signed [31:0]          point_x,
	input  logic signed [31:0]          point_y,
	input  logic signed [31:0]          point_z,
	input  logic [31:0]                 query_time,
	input  logic [31:0]                 start_time,
	input  logic [31:0]                 knot_interval,
	input  logic                        q_pop,
	output logic                        q_vld,
	output bspl_pkg::item_t             q_item
);
	import bspl_pkg::*;

	item_t             fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	item_t             in_item;

	// classify the incoming transaction
	always_comb begin
		in_item.is_query = (req_type == REQ_QUERY);
		in_item.bad      = (query_time < start_time) || (knot_interval == '0);
		in_item.stamp    = query_time - start_time;
		in_item.index    = point_index;
		in_item.x        = point_x;
		in_item.y        = point_y;
		in_item.z        = point_z;
	end

	assign busy   = (cnt_q == QCNT_W'(QDEPTH));
	assign push   = start && !busy;
	assign q_vld  = (cnt_q != '0);
	assign q_item = fifo_q[rp_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (q_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(q_pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= in_item;
		end
	end

endmodule

/* hw/rtl/bspl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_back: table store and query sequencer
// Writes loads into the point table; for queries divides by the interval,
// reads four points, builds basis weights and accumulates on one shared
// multiplier, then scales velocity and acceleration on the divider.
// ----------------------------------------------------------------------------
module bspl_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_vld,
	input  bspl_pkg::item_t            q_item,
	output logic                       q_pop,
	input  logic [31:0]                knot_interval,
	input  logic [bspl_pkg::CNT_W-1:0] cnt,
	output logic                       done,
	output logic                       valid_res,
	output logic signed [31:0]         pos_x,
	output logic signed [31:0]         pos_y,
	output logic signed [31:0]         pos_z,
	output logic signed [31:0]         vel_x,
	output logic signed [31:0]         vel_y,
	output logic signed [31:0]         vel_z,
	output logic signed [31:0]         acc_x,
	output logic signed [31:0]         acc_y,
	output logic signed [31:0]         acc_z
);
	import bspl_pkg::*;

	back_state_t st_q, st_d;

	logic [95:0]       mem [MAX_POINTS];
	logic [95:0]       rd_q;
	logic [PIDX_W-1:0] rd_addr;
	logic              mem_we;

	logic [31:0]       stamp_q;
	logic [15:0]       u_q;
	logic [PIDX_W-1:0] base_q;
	logic [2:0]        rc_q;
	logic [3:0]        ws_q;
	logic [1:0]        ax_q, kd_q, tm_q;
	logic [1:0]        fa_q, fk_q;
	logic              pv_q;
	logic [3:0]        pacc_q;
	logic [95:0]       p_q [4];
	logic signed [32:0] d_q [3][3];
	logic [31:0]       u2_q;
	logic [47:0]       u3_q;
	logic [63:0]       ivsq_q;
	logic signed [30:0] w_q [9];
	logic signed [63:0] acc_q [9];
	logic signed [67:0] prod_q;
	logic signed [33:0] ma, mb;
	logic signed [31:0] res_q [9];
	logic              vres_q;

	logic              div_go, div_done;
	logic [DVD_W-1:0]  div_dvd, div_quo, fq_div, fq_pos;
	logic [DVS_W-1:0]  div_dvs;

	logic [31:0]       seg;
	logic              chk_ok;
	logic              mul_last, fin_last;
	logic [3:0]        fidx, acc_idx;
	logic signed [63:0] facc;
	logic              fneg;
	logic [63:0]       fmag;

	// multiplicand for the weight steps: numerators ready for a divide by 3
	function automatic logic [32:0] wt_y(input logic [3:0] s, input logic [15:0] u,
			input logic [31:0] u2, input logic [47:0] u3);
		logic [51:0] n, u52, u2n, u3n;
		logic [35:0] x, u36, u2x;
		logic [32:0] y;
		n   = '0;
		x   = '0;
		y   = '0;
		u52 = 52'(u);
		u2n = 52'(u2);
		u3n = 52'(u3);
		u36 = 36'(u);
		u2x = 36'(u2);
		case (s)
			4'd3: begin
				n = (52'd5 << 48) + ((u52 * 52'd3) << 32) - ((u2n * 52'd3) << 16) + u3n;
				y = 33'((n + (52'd3 << 19)) >> 20);
			end
			4'd4: begin
				n = (52'd1 << 48) + ((u52 * 52'd3) << 32) + ((u2n * 52'd3) << 16)
					- (u3n << 1);
				y = 33'((n + (52'd3 << 19)) >> 20);
			end
			4'd5: begin
				y = 33'((u3n + (52'd3 << 19)) >> 20);
			end
			4'd6: begin
				x = (36'd3 << 32) - ((u36 * 36'd6) << 16) + u2x * 36'd3 + 36'd24;
				y = 33'(x >> 4);
			end
			4'd7: begin
				x = (36'd3 << 32) + ((u36 * 36'd6) << 16) - u2x * 36'd6 + 36'd24;
				y = 33'(x >> 4);
			end
			4'd8: begin
				x = u2x * 36'd3 + 36'd24;
				y = 33'(x >> 4);
			end
			default: begin
				y = '0;
			end
		endcase
		wt_y = y;
	endfunction

	bspl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go),
		.dvd   (div_dvd),
		.dvs   (div_dvs),
		.done  (div_done),
		.quo   (div_quo)
	);

	// decode and shared accumulator port
	always_comb begin
		seg      = div_quo[DVD_W-1:16];
		chk_ok   = (seg >= 32'd2) && (({1'b0, seg} + 33'd1) < 33'(cnt));
		mul_last = (ax_q == 2'd2) && (kd_q == 2'd2) && (tm_q == 2'd2);
		fin_last = (fa_q == 2'd2) && (fk_q == 2'd2);
		fidx     = idx9(fa_q, fk_q);
		acc_idx  = pv_q ? pacc_q : fidx;
		facc     = acc_q[acc_idx];
		fneg     = facc[63];
		fmag     = fneg ? unsigned'(-facc) : unsigned'(facc);
		fq_pos   = DVD_W'(fmag[63:28]) - DVD_W'(fmag[63:29]);
		fq_div   = div_quo - (div_quo >> 1);
		rd_addr  = base_q + PIDX_W'(rc_q[1:0]);
		div_dvd  = (st_q == S_DGO) ? {stamp_q, 16'b0} : DVD_W'(fmag[63:28]);
		div_dvs  = ((st_q == S_DGO) || (fk_q == 2'd1)) ? DVS_W'(knot_interval) : ivsq_q;
	end

	// shared multiplier operands
	always_comb begin
		ma = '0;
		mb = '0;
		if (st_q == S_WT) begin
			if (ws_q == 4'd0) begin
				ma = 34'(u_q);
				mb = 34'(u_q);
			end else if (ws_q == 4'd1) begin
				ma = 34'(prod_q[31:0]);
				mb = 34'(u_q);
			end else if (ws_q == 4'd2) begin
				ma = 34'(knot_interval);
				mb = 34'(knot_interval);
			end else if (ws_q inside {[4'd3:4'd8]}) begin
				ma = 34'(wt_y(ws_q, u_q, u2_q, u3_q));
				mb = RECIP3;
			end
		end else if (st_q == S_MUL) begin
			ma = 34'(w_q[idx9(kd_q, tm_q)]);
			mb = 34'(d_q[ax_q][tm_q]);
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (q_vld && q_item.is_query) begin
					st_d = q_item.bad ? S_EMIT : S_DGO;
				end
			end
			S_DGO:   st_d = S_DWAIT;
			S_DWAIT: if (div_done) st_d = S_CHK;
			S_CHK:   st_d = chk_ok ? S_RD : S_EMIT;
			S_RD:    if (rc_q == 3'd4) st_d = S_WT;
			S_WT:    if (ws_q == 4'd9) st_d = S_MUL;
			S_MUL:   if (mul_last) st_d = S_MACC;
			S_MACC:  st_d = S_FIN;
			S_FIN: begin
				if (fk_q != 2'd0) begin
					st_d = S_FGO;
				end else if (fin_last) begin
					st_d = S_EMIT;
				end
			end
			S_FGO:   st_d = S_FWAIT;
			S_FWAIT: if (div_done) st_d = fin_last ? S_EMIT : S_FIN;
			S_EMIT:  st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop  = (st_q == S_IDLE) && q_vld;
		mem_we = q_pop && !q_item.is_query;
		div_go = (st_q == S_DGO) || (st_q == S_FGO);
		done   = (st_q == S_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			pv_q <= (st_q == S_MUL);
		end
	end

	// point table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_item.index] <= {q_item.z, q_item.y, q_item.x};
		end
		rd_q <= mem[rd_addr];
	end

	// multiplier output register
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	// query datapath
	always_ff @(posedge clk) begin
		if (pv_q) begin
			acc_q[pacc_q] <= facc + signed'(prod_q[63:0]);
		end
		case (st_q)
			S_IDLE: begin
				if (q_vld && q_item.is_query) begin
					stamp_q <= q_item.stamp;
					vres_q  <= 1'b0;
					for (int i = 0; i < 9; i++) begin
						res_q[i] <= '0;
					end
				end
			end
			S_CHK: begin
				u_q    <= div_quo[15:0];
				base_q <= div_quo[PIDX_W+15:16] - PIDX_W'(2);
				rc_q   <= '0;
				vres_q <= chk_ok;
			end
			S_RD: begin
				rc_q <= rc_q + 1'b1;
				ws_q <= '0;
				if (rc_q != 3'd0) begin
					p_q[rc_q[1:0] - 2'd1] <= rd_q;
				end
			end
			S_WT: begin
				ws_q <= ws_q + 1'b1;
				if (ws_q == 4'd0) begin
					// point differences per axis
					for (int k = 0; k < 3; k++) begin
						for (int j = 0; j < 3; j++) begin
							d_q[k][j] <= 33'(signed'(p_q[j+1][k*32 +: 32]))
								- 33'(signed'(p_q[j][k*32 +: 32]));
						end
					end
				end
				if (ws_q == 4'd1) u2_q   <= prod_q[31:0];
				if (ws_q == 4'd2) u3_q   <= prod_q[47:0];
				if (ws_q == 4'd3) ivsq_q <= prod_q[63:0];
				if (ws_q inside {[4'd4:4'd9]}) begin
					w_q[ws_q - 4'd4] <= 31'(prod_q[62:33]);
				end
				if (ws_q == 4'd9) begin
					// acceleration weights are exact
					w_q[6] <= (signed'(31'(u_q)) - 31'sd65536) <<< 13;
					w_q[7] <= (31'sd65536 - (signed'(31'(u_q)) <<< 1)) <<< 13;
					w_q[8] <= signed'(31'(u_q)) <<< 13;
					ax_q <= '0;
					kd_q <= '0;
					tm_q <= '0;
					for (int k = 0; k < 3; k++) begin
						acc_q[k*3]     <= 64'(signed'(p_q[0][k*32 +: 32])) <<< 29;
						acc_q[k*3 + 1] <= '0;
						acc_q[k*3 + 2] <= '0;
					end
				end
			end
			S_MUL: begin
				pacc_q <= idx9(ax_q, kd_q);
				if (tm_q == 2'd2) begin
					tm_q <= '0;
					if (kd_q == 2'd2) begin
						kd_q <= '0;
						ax_q <= ax_q + 1'b1;
					end else begin
						kd_q <= kd_q + 1'b1;
					end
				end else begin
					tm_q <= tm_q + 1'b1;
				end
			end
			S_MACC: begin
				fa_q <= '0;
				fk_q <= '0;
			end
			S_FIN: begin
				if (fk_q == 2'd0) begin
					res_q[fidx] <= sat32(fneg, fq_pos);
					fk_q <= fk_q + 1'b1;
				end
			end
			S_FWAIT: begin
				if (div_done) begin
					res_q[fidx] <= sat32(fneg, fq_div);
					if (fk_q == 2'd2) begin
						fk_q <= '0;
						fa_q <= fa_q + 1'b1;
					end else begin
						fk_q <= fk_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign valid_res = vres_q;
	assign pos_x     = res_q[0];
	assign vel_x     = res_q[1];
	assign acc_x     = res_q[2];
	assign pos_y     = res_q[3];
	assign vel_y     = res_q[4];
	assign acc_y     = res_q[5];
	assign pos_z     = res_q[6];
	assign vel_z     = res_q[7];
	assign acc_z     = res_q[8];

endmodule

/* hw/rtl/cubic_bspline_trajectory_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bspline_trajectory_eval: uniform cubic B-spline trajectory evaluator
// Holds a table of 3-D control points and returns position, velocity and
// acceleration in Q16.16 for a queried time.
//
//  channel   handshake            payload
//  request   start / busy         req_type, point_index, point_x/y/z, query_time
//  result    done (1-cycle strobe) valid_res, pos_*, vel_*, acc_*
//  config    cfg_we               cfg_idx, cfg_wdata
//
// A load is written to the table as the back end takes it and gives no
// result. A query makes seven passes of the 48-step shared divider
// (interval split, then three velocity and three acceleration scalings),
// plus its steps on the shared multiplier; an out-of-range query ends early.
// A two-entry queue sits between intake and evaluation; busy is high while
// it is full. Results cannot be held off. Reset clears control state only;
// the point table holds whatever was last loaded.
// ----------------------------------------------------------------------------
module cubic_bspline_trajectory_eval (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [bspl_pkg::PIDX_W-1:0] point_index,
	input  logic signed [31:0]          point_x,
	input  logic signed [31:0]          point_y,
	input  logic signed [31:0]          point_z,
	input  logic [31:0]                 query_time,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_idx,
	input  logic [31:0]                 cfg_wdata,
	output logic                        done,
	output logic                        valid_res,
	output logic signed [31:0]          pos_x,
	output logic signed [31:0]          pos_y,
	output logic signed [31:0]          pos_z,
	output logic signed [31:0]          vel_x,
	output logic signed [31:0]          vel_y,
	output logic signed [31:0]          vel_z,
	output logic signed [31:0]          acc_x,
	output logic signed [31:0]          acc_y,
	output logic signed [31:0]          acc_z
);
	import bspl_pkg::*;

	logic [31:0]      interval_q;
	logic [31:0]      start_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_eff;
	logic             q_pop, q_vld;
	item_t            q_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= 32'd1000;
			start_q    <= '0;
			count_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_INTERVAL: interval_q <= cfg_wdata;
				CFG_START:    start_q    <= cfg_wdata;
				CFG_COUNT:    count_q    <= cfg_wdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// point count is clamped to the table depth
	assign count_eff = (count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_q;

	bspl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.point_index  (point_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.query_time   (query_time),
		.start_time   (start_q),
		.knot_interval(interval_q),
		.q_pop        (q_pop),
		.q_vld        (q_vld),
		.q_item       (q_item)
	);

	bspl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_vld        (q_vld),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.knot_interval(interval_q),
		.cnt          (count_eff),
		.done         (done),
		.valid_res    (valid_res),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.vel_z        (vel_z),
		.acc_x        (acc_x),
		.acc_y        (acc_y),
		.acc_z        (acc_z)
	);

	// a result never lasts more than one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// an out-of-range query reports all zeros
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !valid_res |-> pos_x == 0 && pos_y == 0 && pos_z == 0 &&
			vel_x == 0 && vel_y == 0 && vel_z == 0 &&
			acc_x == 0 && acc_y == 0 && acc_z == 0)
		else $error("invalid result carries non-zero fields");

	// the queue only fills after a request was offered
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a preceding request");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the cubic B-spline trajectory evaluator
// Loads the control point table and sends queries under several register
// settings and idle patterns. A local fixed-point spline model predicts each
// query transaction. A monitor compares every result strobe with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import bspl_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;   // index past the register list
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES = 600;

	typedef struct packed {
		logic            vld;
		logic [8:0][31:0] f;   // pos x/y/z, vel x/y/z, acc x/y/z
	} traj_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic req_type = REQ_LOAD;
	logic [PIDX_W-1:0] point_index = '0;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic [31:0] query_time = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = CFG_INTERVAL;
	logic [31:0] cfg_wdata = '0;
	logic done, valid_res;
	logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;

	// model state
	longint pts[3][MAX_POINTS];
	longint unsigned m_interval = 1000, m_start = 0, m_count = 0;

	traj_t pending_traj[$];
	bit failed = 0;
	int idle_pct = 0;
	int stall_cnt = 0;
	string fname[9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
		"acc_x", "acc_y", "acc_z"};

	cubic_bspline_trajectory_eval u_top (.*);

	always #4 clk = ~clk;

	// round half away from zero of n / (a*b*2^29), saturated
	function automatic logic [31:0] round_sat(longint n, longint unsigned a,
			longint unsigned b);
		bit neg;
		longint unsigned mag, t, q;
		neg = n < 0;
		mag = n;
		if (neg) mag = -mag;
		t = mag / a;
		q = t / (b << 28) - t / (b << 29);
		if (!neg) return (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
		return (q >= 64'h80000000) ? 32'h80000000 : 32'(-q[31:0]);
	endfunction

	function automatic traj_t spline_eval(logic [31:0] qt);
		traj_t r;
		longint unsigned stamp, seg, idx, rem, cnt;
		longint u, s, s2, s3, p0;
		longint lw[3], vw[3], aw[3], d[3], sp, sv, sa;
		r = '0;
		cnt = (m_count > MAX_POINTS) ? MAX_POINTS : m_count;
		if (qt < m_start || m_interval == 0) return r;
		stamp = qt - m_start;
		seg = stamp / m_interval;
		idx = seg + 1;
		if (seg < 2 || idx >= cnt) return r;
		rem = stamp - seg * m_interval;
		u = (rem << 16) / m_interval;
		s = 65536; s2 = s * s; s3 = s2 * s;
		lw[0] = (5*s3 + 3*u*s2 - 3*u*u*s + u*u*u + 3*524288) / (6*524288);
		lw[1] = (s3 + 3*u*s2 + 3*u*u*s - 2*u*u*u + 3*524288) / (6*524288);
		lw[2] = (u*u*u + 3*524288) / (6*524288);
		vw[0] = (3*s2 - 6*u*s + 3*u*u + 24) / 48;
		vw[1] = (3*s2 + 6*u*s - 6*u*u + 24) / 48;
		vw[2] = (3*u*u + 24) / 48;
		aw[0] = (u - s) * 8192;
		aw[1] = (s - 2*u) * 8192;
		aw[2] = u * 8192;
		r.vld = 1'b1;
		for (int k = 0; k < 3; k++) begin
			p0 = pts[k][idx-3];
			for (int j = 0; j < 3; j++) d[j] = pts[k][idx-2+j] - pts[k][idx-3+j];
			sp = p0 * 536870912; sv = 0; sa = 0;
			for (int j = 0; j < 3; j++) begin
				sp += lw[j] * d[j];
				sv += vw[j] * d[j];
				sa += aw[j] * d[j];
			end
			r.f[k]   = round_sat(sp, 1, 1);
			r.f[3+k] = round_sat(sv, 1, m_interval);
			r.f[6+k] = round_sat(sa, m_interval, m_interval);
		end
		return r;
	endfunction

	// one request transaction; start stays high unless an idle gap follows
	task automatic send_req(logic rt, logic [7:0] slot, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] qt);
		start <= 1'b1;
		req_type <= rt;
		point_index <= slot;
		point_x <= x; point_y <= y; point_z <= z;
		query_time <= qt;
		do @(posedge clk); while (busy);
		if (rt == REQ_LOAD) begin
			pts[0][slot] = longint'(signed'(x));
			pts[1][slot] = longint'(signed'(y));
			pts[2][slot] = longint'(signed'(z));
		end else begin
			pending_traj.push_back(spline_eval(qt));
		end
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	endtask

	task automatic load_pt(logic [7:0] slot, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		send_req(REQ_LOAD, slot, x, y, z, $urandom);
	endtask

	task automatic query_at(logic [31:0] qt);
		send_req(REQ_QUERY, 8'($urandom), $urandom, $urandom, $urandom, qt);
	endtask

	// wait for every outstanding transaction, loads included
	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (pending_traj.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes all registers plus the unused index; block must be idle
	task automatic write_regs(logic [31:0] iv, logic [31:0] st, logic [31:0] cnt);
		cfg_we <= 1'b1; cfg_idx <= CFG_INTERVAL; cfg_wdata <= iv;
		@(posedge clk);
		cfg_idx <= CFG_START; cfg_wdata <= st;
		@(posedge clk);
		cfg_idx <= CFG_COUNT; cfg_wdata <= cnt;
		@(posedge clk);
		cfg_idx <= CFG_SPARE; cfg_wdata <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		m_interval = iv;
		m_start = st;
		m_count = cnt & 32'h1FF;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return {{12{1'b0}}, 20'($urandom)} - 32'h80000;
			2: return {{8{1'b0}}, 24'($urandom)} - 32'h800000;
			default: return {{16{1'b0}}, 16'($urandom)};
		endcase
	endfunction

	// every slot defined before any query can read it
	task automatic test_table_fill();
		for (int i = 0; i < MAX_POINTS; i++) load_pt(8'(i), rand_coord(), rand_coord(), rand_coord());
	endtask

	task automatic test_directed();
		quiesce();
		write_regs(1000, 5000, 256);
		load_pt(0, 32'h7FFFFFFF, 32'h80000000, 32'h0);
		load_pt(1, 32'h80000000, 32'h7FFFFFFF, 32'h10000);
		load_pt(2, 32'h0, 32'h80000000, 32'hFFFF0000);
		load_pt(3, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0);
		query_at(4999);                 // before start time
		query_at(5000);                 // first segment
		query_at(6999);                 // just below the usable range
		query_at(7000);                 // usable range edge, u = 0
		query_at(7500);
		query_at(7999);                 // u close to one
		query_at(5000 + 254*1000 + 999); // last usable segment
		query_at(5000 + 255*1000);      // index reaches the count
		query_at(32'hFFFFFFFF);
		quiesce();
		write_regs(1, 0, 300);          // count above table size
		query_at(2);
		query_at(254);
		query_at(255);
		quiesce();
		write_regs(0, 0, 256);          // zero interval
		query_at(3000);
		query_at(0);
	endtask

	// mostly in-range queries, some reloads and stray times
	task automatic test_random(logic [31:0] iv, logic [31:0] st, logic [31:0] cnt,
			int n, int idle);
		longint unsigned c, seg, qt;
		quiesce();
		write_regs(iv, st, cnt);
		idle_pct = idle;
		c = ((cnt & 32'h1FF) > MAX_POINTS) ? MAX_POINTS : (cnt & 32'h1FF);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2: load_pt(8'($urandom), rand_coord(), rand_coord(), rand_coord());
				3: query_at($urandom);
				default: begin
					if (c > 3 && iv != 0) begin
						seg = $urandom_range(32'(c - 2), 2);
						qt = st + seg * iv + ($urandom % iv);
						query_at(qt[31:0]);
					end else begin
						query_at(st + $urandom_range(5000));
					end
				end
			endcase
		end
	endtask

	// sender holds off until the block has drained
	task automatic test_drain_pause();
		quiesce();
		write_regs(50, 100, 40);
		idle_pct = 0;
		query_at(100 + 50*10 + 17);
		start <= 1'b0;
		@(posedge clk);
		while (pending_traj.size() != 0) @(posedge clk);
		query_at(100 + 50*20 + 49);
		query_at(100 + 50*38 + 1);
	endtask

	// result checker
	always @(posedge clk) begin
		if (done) begin
			if (pending_traj.size() == 0) begin
				$display("%0t: unexpected result transaction", $time);
				failed = 1;
			end else begin
				traj_t e;
				traj_t a;
				e = pending_traj.pop_front();
				a.vld = valid_res;
				a.f = {acc_z, acc_y, acc_x, vel_z, vel_y, vel_x, pos_z, pos_y, pos_x};
				if (a.vld !== e.vld) begin
					$display("%0t: valid_res expected %0d got %0d", $time, e.vld, a.vld);
					failed = 1;
				end
				for (int k = 0; k < 9; k++)
					if (a.f[k] !== e.f[k]) begin
						$display("%0t: %s expected %h got %h", $time, fname[k],
							e.f[k], a.f[k]);
						failed = 1;
					end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_fill();
		test_directed();
		test_random(1000, 0, 256, 40, 0);
		test_random(7, 123456, 10, 30, 80);
		test_random(1, 32'hFFFFF000, 511, 30, 29);
		test_random(32'hFFFFFFFF, 32'hFFFFFFFF, 4, 20, 0);
		test_random(3, 0, 0, 20, 80);
		test_random(65536, 1000, 200, 40, 29);
		test_drain_pause();
		test_random(12345, 77, 256, 40, 0);
		start <= 1'b0;
		@(posedge clk);
		while (pending_traj.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (!failed && pending_traj.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
